### hw/rtl/bmt_pkg.sv
// Shared types and constants for the bitmap transform block.
package bmt_pkg;

  localparam int unsigned FUNC_W = 4;
  localparam int unsigned POS_W = 4;
  localparam int unsigned ROW_BITS_W = 16;
  localparam int unsigned ROW_OUT_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ = 4'd0,
    FN_WRITE_ROW = 4'd1,
    FN_SET_PIXEL = 4'd2,
    FN_ROLL_UP = 4'd3,
    FN_ROLL_DOWN = 4'd4,
    FN_ROLL_LEFT = 4'd5,
    FN_ROLL_RIGHT = 4'd6,
    FN_HMIRROR = 4'd7,
    FN_VMIRROR = 4'd8,
    FN_ROTATE = 4'd9,
    FN_FILL = 4'd10,
    FN_EXCHANGE = 4'd11
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIRST_COLOR = 2'd0,
    CFG_SECOND_COLOR = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic pixel_color;
    logic [ROW_BITS_W-1:0] row_bits;
  } op_t;

endpackage

### hw/rtl/bmt_item_if.sv
// Request channel that carries one bitmap operation.
interface bmt_item_if;
  logic valid;
  logic ready;
  logic [bmt_pkg::FUNC_W-1:0] func;
  logic [bmt_pkg::POS_W-1:0] col;
  logic [bmt_pkg::POS_W-1:0] row;
  logic pixel_color;
  logic [bmt_pkg::ROW_BITS_W-1:0] row_bits;

  modport source (output valid, func, col, row, pixel_color, row_bits, input ready);
  modport sink (input valid, func, col, row, pixel_color, row_bits, output ready);
endinterface

### hw/rtl/bmt_result_if.sv
// Result channel that carries the selected row.
interface bmt_result_if;
  logic valid;
  logic ready;
  logic [bmt_pkg::ROW_OUT_W-1:0] row_out;

  modport source (output valid, row_out, input ready);
  modport sink (input valid, row_out, output ready);
endinterface

### hw/rtl/bmt_cfg_if.sv
// Configuration write channel.
interface bmt_cfg_if;
  logic valid;
  logic ready;
  logic [bmt_pkg::CFG_INDEX_W-1:0] index;
  logic [bmt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/bmt_transform.sv
// Combinational next-bitmap logic for one operation and the selected row.
module bmt_transform #(
  parameter int unsigned SIDE = 16
) (
  input  logic [SIDE-1:0]          rows [SIDE],
  input  bmt_pkg::op_t             op,
  input  logic                     colors_differ,
  output logic [SIDE-1:0]          rows_next [SIDE],
  output logic [bmt_pkg::ROW_OUT_W-1:0] row_out
);
  import bmt_pkg::*;

  localparam int unsigned IDX_W = $clog2(SIDE);
  localparam int unsigned TOP = SIDE - 1;
  localparam logic [POS_W+1:0] SIDE_EXT = (POS_W + 2)'(SIDE);

  logic [POS_W+1:0] row_ext;
  logic [POS_W+1:0] col_ext;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;
  logic [SIDE+ROW_BITS_W-1:0] bits_ext;
  logic [SIDE-1:0] bits;
  logic [SIDE-1:0] pixel_mask;
  logic [SIDE-1:0] rows_up [SIDE];
  logic [SIDE-1:0] rows_down [SIDE];
  logic [SIDE-1:0] rows_left [SIDE];
  logic [SIDE-1:0] rows_right [SIDE];
  logic [SIDE-1:0] rows_hmir [SIDE];
  logic [SIDE-1:0] rows_vmir [SIDE];
  logic [SIDE-1:0] rows_rot [SIDE];
  logic [SIDE-1:0] sel_row;
  logic [SIDE+ROW_OUT_W-1:0] sel_ext;

  // Indices wrap modulo the side; a 4-bit value stays below twice the side.
  always_comb begin
    row_ext = {2'b00, op.row};
    col_ext = {2'b00, op.col};
    if (row_ext >= SIDE_EXT) begin
      row_ext = row_ext - SIDE_EXT;
    end
    if (col_ext >= SIDE_EXT) begin
      col_ext = col_ext - SIDE_EXT;
    end
  end

  assign row_idx = row_ext[IDX_W-1:0];
  assign col_idx = col_ext[IDX_W-1:0];
  assign bits_ext = {{SIDE{1'b0}}, op.row_bits};
  assign bits = bits_ext[SIDE-1:0];

  for (genvar b = 0; b < SIDE; b++) begin : g_mask
    assign pixel_mask[b] = (col_idx == IDX_W'(TOP - b));
  end

  for (genvar y = 0; y < SIDE; y++) begin : g_rows
    assign rows_up[y] = rows[(y + 1) % SIDE];
    assign rows_down[y] = rows[(y + SIDE - 1) % SIDE];
    assign rows_left[y] = {rows[y][SIDE-2:0], rows[y][SIDE-1]};
    assign rows_right[y] = {rows[y][0], rows[y][SIDE-1:1]};
    assign rows_vmir[y] = rows[TOP - y];
    for (genvar b = 0; b < SIDE; b++) begin : g_bits
      assign rows_hmir[y][b] = rows[y][TOP - b];
      assign rows_rot[y][b] = rows[b][TOP - y];
    end
  end

  always_comb begin
    for (int y = 0; y < SIDE; y++) begin
      rows_next[y] = rows[y];
    end
    case (op.func)
      FN_WRITE_ROW: begin
        rows_next[row_idx] = bits;
      end
      FN_SET_PIXEL: begin
        if (op.pixel_color) begin
          rows_next[row_idx] = rows[row_idx] | pixel_mask;
        end else begin
          rows_next[row_idx] = rows[row_idx] & ~pixel_mask;
        end
      end
      FN_ROLL_UP: rows_next = rows_up;
      FN_ROLL_DOWN: rows_next = rows_down;
      FN_ROLL_LEFT: rows_next = rows_left;
      FN_ROLL_RIGHT: rows_next = rows_right;
      FN_HMIRROR: rows_next = rows_hmir;
      FN_VMIRROR: rows_next = rows_vmir;
      FN_ROTATE: rows_next = rows_rot;
      FN_FILL: begin
        for (int y = 0; y < SIDE; y++) begin
          rows_next[y] = {SIDE{op.pixel_color}};
        end
      end
      FN_EXCHANGE: begin
        if (colors_differ) begin
          for (int y = 0; y < SIDE; y++) begin
            rows_next[y] = ~rows[y];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign sel_row = rows_next[row_idx];
  assign sel_ext = {{ROW_OUT_W{1'b0}}, sel_row};
  assign row_out = sel_ext[ROW_OUT_W-1:0];

endmodule

### hw/rtl/bitmap_16x16_transform.sv
// Top level: a square one-bit bitmap held in registers with in-place transforms.
// A request waits in the input register while backpressure holds the result register.
// Throughput: one request per cycle while result.ready holds; every operation is one pass
// through the transform logic. The input and result registers form a two-stage pipeline.
// Reset clears the bitmap, sets first color to one and second color to zero,
// and empties both pipeline stages.
module bitmap_16x16_transform #(
  parameter int unsigned SIDE = 16
) (
  input  logic clk,
  input  logic rst,
  bmt_item_if.sink     item,
  bmt_result_if.source result,
  bmt_cfg_if.sink      cfg
);
  import bmt_pkg::*;

  logic [SIDE-1:0] rows [SIDE];
  logic [SIDE-1:0] rows_next [SIDE];
  op_t op;
  logic op_valid;
  logic out_valid;
  logic [ROW_OUT_W-1:0] row_out;
  logic [ROW_OUT_W-1:0] row_out_next;
  logic first_color;
  logic second_color;
  logic out_free;
  logic advance;

  assign out_free = !out_valid || result.ready;
  assign advance = op_valid && out_free;
  assign item.ready = !op_valid || advance;
  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.row_out = row_out;

  bmt_transform #(
    .SIDE(SIDE)
  ) u_transform (
    .rows(rows),
    .op(op),
    .colors_differ(first_color != second_color),
    .rows_next(rows_next),
    .row_out(row_out_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        op_valid <= item.valid;
      end
      if (out_free) begin
        out_valid <= op_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      op.func <= item.func;
      op.col <= item.col;
      op.row <= item.row;
      op.pixel_color <= item.pixel_color;
      op.row_bits <= item.row_bits;
    end
    if (advance) begin
      row_out <= row_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < SIDE; y++) begin
        rows[y] <= '0;
      end
    end else if (advance) begin
      rows <= rows_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_color <= 1'b1;
      second_color <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_FIRST_COLOR: first_color <= cfg.data[0];
        CFG_SECOND_COLOR: second_color <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule
